[hdl/wlw_pkg.sv]
// Shared types, constants and helpers for the weight layout walker.
`default_nettype none
package wlw_pkg;

  localparam int KERNEL_BLOCK_DEF  = 32;
  localparam int CHANNEL_GROUP_DEF = 64;
  localparam int PAD_ALIGN_DEF     = 128;

  localparam int KC_W   = 11;  // kernel and channel count registers
  localparam int HW_W   = 9;   // height and width count registers
  localparam int KC_POS = 10;  // kernel and channel coordinates
  localparam int HW_POS = 8;   // row and column coordinates

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;

  localparam logic [KC_W-1:0] KC_MAX = 11'd1024;
  localparam logic [KC_W-1:0] HW_MAX = 11'd256;

  typedef enum logic [CFG_AW-1:0] {
    REG_KERNEL_COUNT  = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_HEIGHT_COUNT  = 2'd2,
    REG_WIDTH_COUNT   = 2'd3
  } cfg_reg_t;

  // Current walk position plus the base of the active kernel and channel groups.
  typedef struct packed {
    logic [KC_POS-1:0] kernel;
    logic [KC_POS-1:0] channel;
    logic [HW_POS-1:0] row;
    logic [HW_POS-1:0] column;
    logic [KC_POS-1:0] kernel_base;
    logic [KC_POS-1:0] channel_base;
  } pos_t;

  // Effective tensor dimensions after clamping.
  typedef struct packed {
    logic [KC_W-1:0] kernels;
    logic [KC_W-1:0] channels;
    logic [HW_W-1:0] rows;
    logic [HW_W-1:0] columns;
  } dims_t;

  // A count of zero means one; anything above the limit means the limit.
  function automatic logic [KC_W-1:0] clamp_count(input logic [KC_W-1:0] v,
                                                  input logic [KC_W-1:0] hi);
    logic [KC_W-1:0] r;
    if (v == '0) begin
      r = {{(KC_W-1){1'b0}}, 1'b1};
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/wlw_advance.sv]
// Next-position logic of the grouped walk order.
`default_nettype none
module wlw_advance #(
  parameter int KERNEL_BLOCK  = wlw_pkg::KERNEL_BLOCK_DEF,
  parameter int CHANNEL_GROUP = wlw_pkg::CHANNEL_GROUP_DEF
) (
  input  wlw_pkg::pos_t  cur,
  input  wlw_pkg::dims_t dims,
  output wlw_pkg::pos_t  nxt,
  output logic           more
);

  logic [wlw_pkg::KC_W-1:0] c_inc, k_inc, c_grp_end, k_grp_end;
  logic [wlw_pkg::HW_W-1:0] h_inc, w_inc;

  assign c_inc     = {1'b0, cur.channel} + wlw_pkg::KC_W'(1);
  assign k_inc     = {1'b0, cur.kernel} + wlw_pkg::KC_W'(1);
  assign c_grp_end = {1'b0, cur.channel_base} + wlw_pkg::KC_W'(CHANNEL_GROUP);
  assign k_grp_end = {1'b0, cur.kernel_base} + wlw_pkg::KC_W'(KERNEL_BLOCK);
  assign h_inc     = {1'b0, cur.row} + wlw_pkg::HW_W'(1);
  assign w_inc     = {1'b0, cur.column} + wlw_pkg::HW_W'(1);

  // Priority: channel in group, kernel in group, column, row, next channel
  // group, next kernel group. The position stays put once the walk is done.
  always_comb begin
    nxt  = cur;
    more = 1'b1;
    if (c_inc != c_grp_end && c_inc < dims.channels) begin
      nxt.channel = c_inc[wlw_pkg::KC_POS-1:0];
    end else if (k_inc != k_grp_end && k_inc < dims.kernels) begin
      nxt.kernel  = k_inc[wlw_pkg::KC_POS-1:0];
      nxt.channel = cur.channel_base;
    end else if (w_inc < dims.columns) begin
      nxt.kernel  = cur.kernel_base;
      nxt.channel = cur.channel_base;
      nxt.column  = w_inc[wlw_pkg::HW_POS-1:0];
    end else if (h_inc < dims.rows) begin
      nxt.kernel  = cur.kernel_base;
      nxt.channel = cur.channel_base;
      nxt.row     = h_inc[wlw_pkg::HW_POS-1:0];
      nxt.column  = '0;
    end else if (c_inc < dims.channels) begin
      nxt.kernel       = cur.kernel_base;
      nxt.channel      = c_inc[wlw_pkg::KC_POS-1:0];
      nxt.channel_base = c_inc[wlw_pkg::KC_POS-1:0];
      nxt.row          = '0;
      nxt.column       = '0;
    end else if (k_inc < dims.kernels) begin
      nxt.kernel       = k_inc[wlw_pkg::KC_POS-1:0];
      nxt.kernel_base  = k_inc[wlw_pkg::KC_POS-1:0];
      nxt.channel      = '0;
      nxt.channel_base = '0;
      nxt.row          = '0;
      nxt.column       = '0;
    end else begin
      more = 1'b0;
    end
  end

endmodule
`default_nettype wire

[hdl/weight_layout_walker.sv]
// Top level of the weight layout walker: handshake stages, walk state and config.
//
// The walker produces, one per input transaction, the source coordinates of the
// next destination byte of a weight tensor laid out in grouped order: channels
// fastest within a channel group, then kernels within a kernel group, then
// column, then row, then the next channel group, then the next kernel group.
// After the last element it emits pad slots (is_pad set, coordinates zero) until
// the output length reaches a multiple of PAD_ALIGN; the final byte carries
// tlast and the walk begins again from the first element.
// Input channel: each transaction carries a restart flag in in_tdata bit 0;
// restart set begins a new walk before this transaction's result.
// Output channel: one result transaction per input transaction, in order.
// A transaction passes the input register, then the result register, before its
// result appears. Throughput is one transaction per cycle while the receiver does
// not stall, as the combinational position update feeds the walk registers.
// A stalled receiver holds the result register; the input register still takes
// one more transaction, and in_tready drops only while both stages are full.
// Reset clears both stages, the walk position and the pad phase, and sets all
// four dimension registers to one, which the user writes through cfg_we/cfg_addr/
// cfg_wdata only while the walker is idle; the block itself does not enforce this.
`default_nettype none
module weight_layout_walker #(
  parameter int KERNEL_BLOCK  = wlw_pkg::KERNEL_BLOCK_DEF,
  parameter int CHANNEL_GROUP = wlw_pkg::CHANNEL_GROUP_DEF,
  parameter int PAD_ALIGN     = wlw_pkg::PAD_ALIGN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [wlw_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [wlw_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [0] restart, [7:1] zero
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [9:0] kernel_index, [19:10] channel_index, [27:20] row_index,
  // [35:28] column_index, [39:36] zero
  output logic [39:0]                     out_tdata,
  output logic                            out_tuser,  // [0] is_pad
  output logic                            out_tlast   // is_last
);

  localparam int PW = (PAD_ALIGN > 1) ? $clog2(PAD_ALIGN) : 1;

  // Configuration registers.
  logic [wlw_pkg::KC_W-1:0] kernel_count_r, channel_count_r;
  logic [wlw_pkg::HW_W-1:0] height_count_r, width_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_count_r  <= wlw_pkg::KC_W'(1);
      channel_count_r <= wlw_pkg::KC_W'(1);
      height_count_r  <= wlw_pkg::HW_W'(1);
      width_count_r   <= wlw_pkg::HW_W'(1);
    end else if (cfg_we) begin
      unique case (wlw_pkg::cfg_reg_t'(cfg_addr))
        wlw_pkg::REG_KERNEL_COUNT:  kernel_count_r  <= cfg_wdata[wlw_pkg::KC_W-1:0];
        wlw_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[wlw_pkg::KC_W-1:0];
        wlw_pkg::REG_HEIGHT_COUNT:  height_count_r  <= cfg_wdata[wlw_pkg::HW_W-1:0];
        wlw_pkg::REG_WIDTH_COUNT:   width_count_r   <= cfg_wdata[wlw_pkg::HW_W-1:0];
        default: ;
      endcase
    end
  end

  wlw_pkg::dims_t dims;
  logic [wlw_pkg::KC_W-1:0] rows_wide, cols_wide;

  assign rows_wide = wlw_pkg::clamp_count({2'b00, height_count_r}, wlw_pkg::HW_MAX);
  assign cols_wide = wlw_pkg::clamp_count({2'b00, width_count_r}, wlw_pkg::HW_MAX);
  assign dims.kernels  = wlw_pkg::clamp_count(kernel_count_r, wlw_pkg::KC_MAX);
  assign dims.channels = wlw_pkg::clamp_count(channel_count_r, wlw_pkg::KC_MAX);
  assign dims.rows     = rows_wide[wlw_pkg::HW_W-1:0];
  assign dims.columns  = cols_wide[wlw_pkg::HW_W-1:0];

  // Handshake stages: the input register feeds the result register whenever
  // the result register is empty or being drained this cycle.
  logic s1_valid_r, s1_restart_r;
  logic out_valid_r, out_free, step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_restart_r <= in_tdata[0];
    end
  end

  // Walk state.
  wlw_pkg::pos_t   pos_r, pos_nxt, cur, adv_pos;
  logic [PW-1:0]   phase_r, phase_nxt, phase_cur, phase_inc;
  logic            pad_r, pad_nxt, pad_cur, more, walk_done, last;

  // A restart clears the position, the phase and any padding before this
  // transaction's result is formed.
  assign cur       = s1_restart_r ? '0 : pos_r;
  assign phase_cur = s1_restart_r ? '0 : phase_r;
  assign pad_cur   = s1_restart_r ? 1'b0 : pad_r;

  wlw_advance #(
    .KERNEL_BLOCK  (KERNEL_BLOCK),
    .CHANNEL_GROUP (CHANNEL_GROUP)
  ) u_advance (
    .cur  (cur),
    .dims (dims),
    .nxt  (adv_pos),
    .more (more)
  );

  assign phase_inc = (phase_cur == PW'(PAD_ALIGN - 1)) ? '0 : phase_cur + PW'(1);
  assign walk_done = pad_cur || !more;
  assign last      = walk_done && (phase_inc == '0);

  always_comb begin
    pos_nxt   = pad_cur ? cur : adv_pos;
    phase_nxt = phase_inc;
    pad_nxt   = pad_cur;
    if (last) begin
      // The padded output is complete; the next transaction starts over.
      pos_nxt   = '0;
      phase_nxt = '0;
      pad_nxt   = 1'b0;
    end else if (walk_done) begin
      pad_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
      pad_r   <= 1'b0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (pad_cur) begin
        out_tdata <= '0;
      end else begin
        out_tdata <= {4'b0000, cur.column, cur.row, cur.channel, cur.kernel};
      end
      out_tuser <= pad_cur;
      out_tlast <= last;
    end
  end

  assign out_tvalid = out_valid_r;

  // Pad slots always carry zero coordinates.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("pad slot with nonzero coordinates");

  // A restart never yields a pad slot.
  a_restart_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_restart_r) |=> (out_tvalid && !out_tuser))
    else $error("restart produced a pad slot");

  // Padding never rests on an alignment boundary.
  a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r |-> (phase_r != '0))
    else $error("padding active at phase zero");

  // The phase stays below the alignment.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, phase_r} < (PW + 1)'(PAD_ALIGN)))
    else $error("byte phase out of range");

  // Input is refused only while both stages are full and the output stalls.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input refused without backpressure");

endmodule
`default_nettype wire

[test/weight_layout_walker_test.sv]
// Self-checking testbench for the weight layout walker: directed walks, then random ones.
`timescale 1ns / 100ps

module weight_layout_walker_test;

  // The slowest correct run stays far below this, even with both sides stalling.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 200;

  // One destination byte slot as the walker should report it.
  typedef struct {
    logic [wlw_pkg::KC_POS-1:0] kernel;
    logic [wlw_pkg::KC_POS-1:0] channel;
    logic [wlw_pkg::HW_POS-1:0] row;
    logic [wlw_pkg::HW_POS-1:0] column;
    logic                       is_pad;
    logic                       is_last;
  } slot_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [wlw_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [wlw_pkg::CFG_DW-1:0] cfg_wdata = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata = '0;   // [0] restart, [7:1] zero
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  // [9:0] kernel_index, [19:10] channel_index, [27:20] row_index,
  // [35:28] column_index, [39:36] zero
  logic [39:0]                out_tdata;
  logic                       out_tuser;       // [0] is_pad
  logic                       out_tlast;       // is_last

  weight_layout_walker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected slots, oldest first, filled when an input transaction is accepted.
  slot_t pending_slots[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  // While set, neither side idles; this gives long back-to-back stretches.
  bit    steady = 1'b0;

  // Shadow of the dimension registers, masked to their widths as written.
  logic [wlw_pkg::KC_W-1:0]   kernel_reg = wlw_pkg::KC_W'(1);
  logic [wlw_pkg::KC_W-1:0]   channel_reg = wlw_pkg::KC_W'(1);
  logic [wlw_pkg::HW_W-1:0]   height_reg = wlw_pkg::HW_W'(1);
  logic [wlw_pkg::HW_W-1:0]   width_reg = wlw_pkg::HW_W'(1);

  // Shadow of the walk: next element, bytes emitted modulo 128, pad flag.
  logic [wlw_pkg::KC_POS-1:0] kernel_at = '0;
  logic [wlw_pkg::KC_POS-1:0] channel_at = '0;
  logic [wlw_pkg::HW_POS-1:0] row_at = '0;
  logic [wlw_pkg::HW_POS-1:0] column_at = '0;
  logic [6:0]                 byte_count = '0;
  bit                         padding = 1'b0;

  // ---------------------------------------------------------------------------
  // Walk predictor
  // ---------------------------------------------------------------------------

  // A zero count means one; a count above the limit means the limit.
  function automatic int unsigned effective_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void rewind_walk();
    kernel_at  = '0;
    channel_at = '0;
    row_at     = '0;
    column_at  = '0;
    byte_count = '0;
    padding    = 1'b0;
  endfunction

  // Moves to the next element in grouped order. Returns 0 once the walk is over.
  function automatic bit step_position();
    int unsigned kk, cc, hh, ww, k, c, h, w, cbase, kbase;
    kk = effective_dim(32'(kernel_reg), 1024);
    cc = effective_dim(32'(channel_reg), 1024);
    hh = effective_dim(32'(height_reg), 256);
    ww = effective_dim(32'(width_reg), 256);
    k = 32'(kernel_at);
    c = 32'(channel_at);
    h = 32'(row_at);
    w = 32'(column_at);
    cbase = c - c % wlw_pkg::CHANNEL_GROUP_DEF;
    kbase = k - k % wlw_pkg::KERNEL_BLOCK_DEF;
    if ((c + 1) % wlw_pkg::CHANNEL_GROUP_DEF != 0 && c + 1 < cc) begin
      // Next channel inside the current channel group.
      c = c + 1;
    end else if ((k + 1) % wlw_pkg::KERNEL_BLOCK_DEF != 0 && k + 1 < kk) begin
      // Next kernel inside the kernel group, channels back to the group base.
      k = k + 1;
      c = cbase;
    end else if (w + 1 < ww) begin
      k = kbase;
      c = cbase;
      w = w + 1;
    end else if (h + 1 < hh) begin
      k = kbase;
      c = cbase;
      h = h + 1;
      w = 0;
    end else if (c + 1 < cc) begin
      // Spatial plane done: on to the next channel group.
      k = kbase;
      c = c + 1;
      h = 0;
      w = 0;
    end else if (k + 1 < kk) begin
      // All channel groups done: on to the next kernel group.
      k = k + 1;
      c = 0;
      h = 0;
      w = 0;
    end else begin
      return 1'b0;
    end
    kernel_at  = k[wlw_pkg::KC_POS-1:0];
    channel_at = c[wlw_pkg::KC_POS-1:0];
    row_at     = h[wlw_pkg::HW_POS-1:0];
    column_at  = w[wlw_pkg::HW_POS-1:0];
    return 1'b1;
  endfunction

  // Works out the slot for one accepted transaction and advances the shadow walk.
  function automatic slot_t next_byte_slot(input bit restart);
    slot_t s;
    bit    more;
    if (restart) rewind_walk();
    if (padding) begin
      s = '{kernel: '0, channel: '0, row: '0, column: '0, is_pad: 1'b1, is_last: 1'b0};
      more = 1'b1;
    end else begin
      s = '{kernel: kernel_at, channel: channel_at, row: row_at, column: column_at,
            is_pad: 1'b0, is_last: 1'b0};
      more = step_position();
    end
    // Seven bits wrap exactly at the 128-byte alignment.
    byte_count = byte_count + 7'd1;
    if (!more || padding) begin
      if (byte_count == '0) begin
        s.is_last = 1'b1;
        rewind_walk();
      end else begin
        padding = 1'b1;
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    mismatch_count++;
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  task automatic check_result();
    slot_t want;
    if (pending_slots.size() == 0) begin
      mismatch_count++;
      $error("result transaction arrived with no expected slot pending");
    end else begin
      want = pending_slots.pop_front();
      if (out_tdata[9:0] !== want.kernel)
        flag_field("kernel_index", 32'(want.kernel), 32'(out_tdata[9:0]));
      if (out_tdata[19:10] !== want.channel)
        flag_field("channel_index", 32'(want.channel), 32'(out_tdata[19:10]));
      if (out_tdata[27:20] !== want.row)
        flag_field("row_index", 32'(want.row), 32'(out_tdata[27:20]));
      if (out_tdata[35:28] !== want.column)
        flag_field("column_index", 32'(want.column), 32'(out_tdata[35:28]));
      if (out_tuser !== want.is_pad)
        flag_field("is_pad", 32'(want.is_pad), 32'(out_tuser));
      if (out_tlast !== want.is_last)
        flag_field("is_last", 32'(want.is_last), 32'(out_tlast));
    end
  endtask

  // Results are sampled at the edge with the values that stood before it; the
  // new ready level is then scheduled for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result();
      out_tready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("weight_layout_walker_test: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one transaction, after a random number of idle cycles, and records
  // its expected slot once it is accepted. in_tvalid stays high on return so
  // that the next transaction can follow back to back.
  task automatic push_item(input bit restart, output bit walk_end);
    slot_t s;
    while (!steady && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    s = next_byte_slot(restart);
    pending_slots.push_back(s);
    walk_end = s.is_last;
  endtask

  // Sends transactions until the walk ends or max_items have gone. Only the
  // first may carry a restart by choice; the rest restart at restart_pct.
  task automatic run_walk(input bit first_restart, input int restart_pct,
                          input int max_items, output int sent);
    bit done;
    bit restart;
    done = 1'b0;
    sent = 0;
    while (!done && sent < max_items) begin
      restart = (sent == 0) ? first_restart : ($urandom_range(99) < restart_pct);
      push_item(restart, done);
      sent++;
    end
  endtask

  // Stops offering input, waits until every expected result is back, and then
  // waits on for the two pipeline stages to empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high; set_dims lowers it once after the last write.
  task automatic write_reg(input wlw_pkg::cfg_reg_t idx,
                           input logic [wlw_pkg::CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      wlw_pkg::REG_KERNEL_COUNT:  kernel_reg  = value[wlw_pkg::KC_W-1:0];
      wlw_pkg::REG_CHANNEL_COUNT: channel_reg = value[wlw_pkg::KC_W-1:0];
      wlw_pkg::REG_HEIGHT_COUNT:  height_reg  = value[wlw_pkg::HW_W-1:0];
      wlw_pkg::REG_WIDTH_COUNT:   width_reg   = value[wlw_pkg::HW_W-1:0];
      default: ;
    endcase
  endtask

  // Must only be called with the walker idle, i.e. right after settle.
  task automatic set_dims(input int unsigned kernels, input int unsigned channels,
                          input int unsigned rows, input int unsigned columns);
    write_reg(wlw_pkg::REG_KERNEL_COUNT, wlw_pkg::CFG_DW'(kernels));
    write_reg(wlw_pkg::REG_CHANNEL_COUNT, wlw_pkg::CFG_DW'(channels));
    write_reg(wlw_pkg::REG_HEIGHT_COUNT, wlw_pkg::CFG_DW'(rows));
    write_reg(wlw_pkg::REG_WIDTH_COUNT, wlw_pkg::CFG_DW'(columns));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With the reset dimensions the tensor is a single element, so the walk is
  // that element, 127 pad slots with the last one flagged, and then again.
  task automatic test_reset_dims();
    int  sent;
    bit  done;
    run_walk(1'b0, 0, 200, sent);
    push_item(1'b0, done);
    push_item(1'b0, done);
  endtask

  // Crossing a channel group boundary, then a kernel group boundary.
  task automatic test_group_boundaries();
    int sent;
    settle();
    set_dims(1, 65, 1, 1);
    run_walk(1'b1, 0, 400, sent);
    settle();
    set_dims(33, 1, 1, 2);
    run_walk(1'b1, 0, 400, sent);
  endtask

  // 2 x 64 elements fill exactly one 128-byte block: the last element itself
  // carries is_last and no pad slot follows.
  task automatic test_aligned_end();
    int sent;
    bit done;
    settle();
    set_dims(2, 64, 1, 1);
    run_walk(1'b1, 0, 200, sent);
    push_item(1'b0, done);
  endtask

  // Restart in the middle of the elements and in the middle of the padding.
  task automatic test_restarts();
    int sent;
    settle();
    set_dims(2, 3, 2, 2);
    run_walk(1'b1, 0, 5, sent);
    run_walk(1'b1, 0, 30, sent);
    run_walk(1'b0, 0, 4, sent);
    run_walk(1'b1, 0, 30, sent);
  endtask

  // Register values at and beyond their limits, and counts changed while a
  // walk is still under way.
  task automatic test_count_limits();
    int sent;
    settle();
    // Zero counts are read as one: one element, then pad slots.
    set_dims(0, 0, 0, 0);
    run_walk(1'b1, 0, 3, sent);
    settle();
    // All ones: above the maximum for kernels and channels; the height and
    // width registers keep nine bits and read that as above 256.
    set_dims('h7FF, 'h7FF, 'h7FF, 'h7FF);
    run_walk(1'b1, 0, 70, sent);
    settle();
    // Exact maxima, walk carried on without a restart.
    set_dims(1024, 1024, 256, 256);
    run_walk(1'b0, 0, 6, sent);
    settle();
    // Height and width written with only bit 9 or 10 set keep zero, read as
    // one; the held channel position is now beyond the new channel count.
    set_dims(2, 3, 'h200, 'h600);
    run_walk(1'b0, 0, 300, sent);
  endtask

  // Random dimensions, mostly small, sometimes just across a group boundary.
  // Most phases run a whole walk with rare stray restarts; some stop partway so
  // that the next phase changes the counts in the middle of a walk. The first
  // phase runs with no idling on either side, and the last one is cut short
  // at the item budget.
  task automatic test_random_walks();
    int          random_sent;
    int          sent;
    int          budget;
    int unsigned kernels, channels, rows, columns;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      do begin
        kernels  = ($urandom_range(3) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 4);
        channels = ($urandom_range(3) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 5);
        rows     = $urandom_range(1, 4);
        columns  = $urandom_range(1, 4);
      end while (kernels * channels * rows * columns > 700);
      settle();
      steady = (random_sent == 0) || ($urandom_range(3) == 0);
      set_dims(kernels, channels, rows, columns);
      if ($urandom_range(9) < 7)
        budget = int'(2 * kernels * channels * rows * columns + 256);
      else
        budget = int'($urandom_range(1, kernels * channels * rows * columns + 128));
      if (budget > RANDOM_ITEMS - random_sent)
        budget = RANDOM_ITEMS - random_sent;
      run_walk($urandom_range(1), 2, budget, sent);
      random_sent += sent;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_dims();
    test_group_boundaries();
    test_aligned_end();
    test_restarts();
    test_count_limits();
    test_random_walks();

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("weight_layout_walker_test: PASS");
    end else begin
      $display("weight_layout_walker_test: FAIL");
    end
    $finish;
  end

endmodule

[weight_layout_walker.f]
hdl/wlw_pkg.sv
hdl/wlw_advance.sv
hdl/weight_layout_walker.sv
test/weight_layout_walker_test.sv
